### rtl/cpeg_pkg.sv
package cpeg_pkg;

  localparam int unsigned AXES    = 3;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CHG_W   = 16;
  localparam int unsigned OUT_W   = 48;
  localparam int unsigned DIFF_W  = POS_W + 1;
  localparam int unsigned MAG_W   = POS_W;
  localparam int unsigned AQ_W    = 2 * CHG_W - 1;
  localparam int unsigned R2_W    = 2 * MAG_W;
  localparam int unsigned K_W     = 5;
  localparam int unsigned RT_W    = R2_W / 2;
  localparam int unsigned CQ_FRAC = 30;
  localparam int unsigned CQ_QW   = CQ_FRAC + 1;
  localparam int unsigned PROD_W  = AQ_W + CQ_QW;
  localparam int unsigned QUO_W   = 64;
  localparam int unsigned GSH_W   = 7;
  localparam int unsigned ESH_W   = 6;
  localparam int unsigned GSH_BASE = QUO_W - 2;
  localparam int unsigned ESH_BASE = QUO_W - 16;

  localparam int unsigned PREP_LAT = 5;
  localparam int unsigned SQRT_LAT = RT_W;
  localparam int unsigned LATENCY  = PREP_LAT + SQRT_LAT + CQ_QW + 1 + QUO_W + 2;

  localparam logic [DIFF_W-1:0] MAG_LIMIT = DIFF_W'(1) << (POS_W - 1);
  localparam logic [R2_W-1:0]   R2_FLOOR  = R2_W'(1) << (R2_W - 2);
  localparam logic [OUT_W-1:0]  POS_CAP   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  NEG_CAP   = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    OP_CROSS = 1'b0,
    OP_INTRA = 1'b1
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic               excluded;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [15:0] first_charge;
    logic signed [15:0] second_charge;
  } pair_t;

  typedef struct packed {
    op_e                        op;
    logic                       excl;
    logic                       zero;
    logic                       qneg;
    logic                       s;
    logic [AXES-1:0]            dneg;
    logic [AQ_W-1:0]            aq;
    logic [AXES-1:0][MAG_W-1:0] magp;
    logic [K_W-1:0]             k;
    logic [R2_W-1:0]            r2n;
  } prep_t;

  typedef struct packed {
    op_e             op;
    logic            excl;
    logic            zero;
    logic            qneg;
    logic            s;
    logic [AXES-1:0] dneg;
    logic [AQ_W-1:0] aq;
    logic [K_W-1:0]  k;
    logic [R2_W-1:0] r2n;
    logic [RT_W-1:0] rn;
  } norm_t;

  typedef struct packed {
    logic             excl;
    logic             zero;
    logic             qneg;
    logic [AXES-1:0]  dneg;
    logic [GSH_W-1:0] gsh;
    logic [ESH_W-1:0] esh;
  } tail_t;

  typedef struct packed {
    logic [OUT_W-1:0] val;
    logic             sat;
  } clip_t;

  function automatic clip_t clip_sign(input logic [QUO_W-1:0] mag, input logic neg);
    clip_t            r;
    logic [QUO_W-1:0] cap;
    logic [QUO_W-1:0] m;
    cap   = neg ? QUO_W'(NEG_CAP) : QUO_W'(POS_CAP);
    r.sat = mag > cap;
    m     = r.sat ? cap : mag;
    r.val = neg ? (OUT_W'(0) - m[OUT_W-1:0]) : m[OUT_W-1:0];
    return r;
  endfunction

endpackage

### rtl/cpeg_pair_if.sv
interface cpeg_pair_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic               excluded;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic signed [15:0] first_charge;
  logic signed [15:0] second_charge;

  modport source (
    output valid, operation, excluded, first_x, first_y, first_z,
    output second_x, second_y, second_z, first_charge, second_charge,
    input  ready
  );

  modport sink (
    input  valid, operation, excluded, first_x, first_y, first_z,
    input  second_x, second_y, second_z, first_charge, second_charge,
    output ready
  );
endinterface

### rtl/cpeg_result_if.sv
interface cpeg_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] energy_term;
  logic signed [47:0] grad_x;
  logic signed [47:0] grad_y;
  logic signed [47:0] grad_z;
  logic               zero_distance;
  logic               saturated;

  modport source (
    output valid, energy_term, grad_x, grad_y, grad_z, zero_distance, saturated,
    input  ready
  );

  modport sink (
    input  valid, energy_term, grad_x, grad_y, grad_z, zero_distance, saturated,
    output ready
  );
endinterface

### rtl/cpeg_delay.sv
module cpeg_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);

  logic [D-1:0] vld_q;
  logic [W-1:0] dat_q [D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[D-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q[0] <= dat_i;
      for (int i = 1; i < D; i++) begin
        dat_q[i] <= dat_q[i-1];
      end
    end
  end

  assign vld_o = vld_q[D-1];
  assign dat_o = dat_q[D-1];

endmodule

### rtl/cpeg_prep.sv
module cpeg_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cpeg_pkg::pair_t pair_i,
  output logic            valid_o,
  output cpeg_pkg::prep_t prep_o
);

  logic [cpeg_pkg::AXES-1:0][cpeg_pkg::POS_W-1:0]  fst;
  logic [cpeg_pkg::AXES-1:0][cpeg_pkg::POS_W-1:0]  snd;
  logic [cpeg_pkg::AXES-1:0][cpeg_pkg::DIFF_W-1:0] diff;
  logic [cpeg_pkg::AXES-1:0]                       dneg_d;
  logic [cpeg_pkg::AXES-1:0][cpeg_pkg::DIFF_W-1:0] mag_d;
  logic signed [2*cpeg_pkg::CHG_W-1:0]             qq;
  logic [cpeg_pkg::AQ_W-1:0]                       aq_d;

  logic                                            s1_vld_q;
  cpeg_pkg::op_e                                   s1_op_q;
  logic                                            s1_excl_q;
  logic                                            s1_qneg_q;
  logic [cpeg_pkg::AXES-1:0]                       s1_dneg_q;
  logic [cpeg_pkg::AXES-1:0][cpeg_pkg::DIFF_W-1:0] s1_mag_q;
  logic [cpeg_pkg::AQ_W-1:0]                       s1_aq_q;

  logic                                            s2_vld_q;
  cpeg_pkg::prep_t                                 s2_d, s2_q;
  logic [cpeg_pkg::AXES-1:0][cpeg_pkg::R2_W-1:0]   sq_d, sq_q;

  logic                                            s3_vld_q;
  cpeg_pkg::prep_t                                 s3_d, s3_q;
  logic [cpeg_pkg::R2_W-1:0]                       r2;

  logic                                            s4_vld_q;
  cpeg_pkg::prep_t                                 s4_d, s4_q;
  logic [cpeg_pkg::R2_W-1:0]                       n4a, n4b;
  logic                                            k4, k3;

  logic                                            s5_vld_q;
  cpeg_pkg::prep_t                                 s5_d, s5_q;
  logic [cpeg_pkg::R2_W-1:0]                       n5a, n5b, n5c;
  logic                                            k2, k1, k0;

  assign fst = {pair_i.first_z, pair_i.first_y, pair_i.first_x};
  assign snd = {pair_i.second_z, pair_i.second_y, pair_i.second_x};

  // per-axis difference and magnitude, charge product
  always_comb begin
    for (int i = 0; i < cpeg_pkg::AXES; i++) begin
      diff[i]   = {snd[i][cpeg_pkg::POS_W-1], snd[i]} - {fst[i][cpeg_pkg::POS_W-1], fst[i]};
      dneg_d[i] = diff[i][cpeg_pkg::DIFF_W-1];
      mag_d[i]  = dneg_d[i] ? (~diff[i] + 1'b1) : diff[i];
    end
    qq   = pair_i.first_charge * pair_i.second_charge;
    aq_d = qq[2*cpeg_pkg::CHG_W-1] ? cpeg_pkg::AQ_W'(-qq) : cpeg_pkg::AQ_W'(qq);
  end

  // prescale and squares
  always_comb begin
    s2_d      = '0;
    s2_d.op   = s1_op_q;
    s2_d.excl = s1_excl_q;
    s2_d.qneg = s1_qneg_q;
    s2_d.dneg = s1_dneg_q;
    s2_d.aq   = s1_aq_q;
    s2_d.s    = 1'b0;
    for (int i = 0; i < cpeg_pkg::AXES; i++) begin
      if (s1_mag_q[i] > cpeg_pkg::MAG_LIMIT) begin
        s2_d.s = 1'b1;
      end
    end
    for (int i = 0; i < cpeg_pkg::AXES; i++) begin
      s2_d.magp[i] = cpeg_pkg::MAG_W'(s1_mag_q[i] >> s2_d.s);
      sq_d[i]      = s2_d.magp[i] * s2_d.magp[i];
    end
  end

  // squared distance, coincident points get a harmless stand-in
  always_comb begin
    r2        = sq_q[0] + sq_q[1] + sq_q[2];
    s3_d      = s2_q;
    s3_d.zero = (r2 == '0);
    s3_d.k    = '0;
    s3_d.r2n  = s3_d.zero ? cpeg_pkg::R2_FLOOR : r2;
  end

  // normalize by even shifts, coarse steps
  always_comb begin
    k4   = (s3_q.r2n[63:32] == '0);
    n4a  = k4 ? (s3_q.r2n << 32) : s3_q.r2n;
    k3   = (n4a[63:48] == '0);
    n4b  = k3 ? (n4a << 16) : n4a;
    s4_d = s3_q;
    s4_d.r2n = n4b;
    s4_d.k   = {k4, k3, 3'b000};
  end

  // normalize, fine steps
  always_comb begin
    k2   = (s4_q.r2n[63:56] == '0);
    n5a  = k2 ? (s4_q.r2n << 8) : s4_q.r2n;
    k1   = (n5a[63:60] == '0);
    n5b  = k1 ? (n5a << 4) : n5a;
    k0   = (n5b[63:62] == '0);
    n5c  = k0 ? (n5b << 2) : n5b;
    s5_d = s4_q;
    s5_d.r2n = n5c;
    s5_d.k   = {s4_q.k[4:3], k2, k1, k0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q   <= pair_i.operation;
      s1_excl_q <= pair_i.excluded;
      s1_qneg_q <= qq[2*cpeg_pkg::CHG_W-1];
      s1_dneg_q <= dneg_d;
      s1_mag_q  <= mag_d;
      s1_aq_q   <= aq_d;
      s2_q      <= s2_d;
      sq_q      <= sq_d;
      s3_q      <= s3_d;
      s4_q      <= s4_d;
      s5_q      <= s5_d;
    end
  end

  assign valid_o = s5_vld_q;
  assign prep_o  = s5_q;

endmodule

### rtl/cpeg_sqrt.sv
module cpeg_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cpeg_pkg::R2_W-1:0] x_i,
  output logic [cpeg_pkg::RT_W-1:0] root_o
);

  localparam int unsigned N   = cpeg_pkg::RT_W;
  localparam int unsigned RMW = N + 2;

  logic [RMW-1:0]            rem_q  [N-1];
  logic [N-1:0]              root_q [N];
  logic [cpeg_pkg::R2_W-1:0] xs_q   [N-1];

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [RMW-1:0]            rem_in;
    logic [N-1:0]              root_in;
    logic [cpeg_pkg::R2_W-1:0] xs_in;
    logic [RMW+1:0]            cur;
    logic [RMW+1:0]            trial;
    logic                      ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign xs_in   = xs_q[g-1];
    end

    assign cur   = {rem_in, xs_in[cpeg_pkg::R2_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[g] <= {root_in[N-2:0], ge};
      end
    end

    if (g < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= ge ? RMW'(cur - trial) : cur[RMW-1:0];
          xs_q[g]  <= xs_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

### rtl/cpeg_div.sv
module cpeg_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] hi_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] lo_q  [QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lo_in;
    logic [DW:0]   cur;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in = hi_i;
      assign den_in = den_i;
      assign lo_in  = lo_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign lo_in  = lo_q[g-1];
    end

    assign cur = {rem_in, lo_in[QW-1]};
    assign ge  = (cur >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[g] <= {lo_in[QW-2:0], ge};
      end
    end

    if (g < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= ge ? DW'(cur - {1'b0, den_in}) : cur[DW-1:0];
          den_q[g] <= den_in;
        end
      end
    end
  end

  assign quo_o = lo_q[QW-1];

endmodule

### rtl/coulomb_pair_energy_gradient_unit.sv
// channel    dir   handshake     word
// pair_i     in    valid/ready   operation, excluded, first_*/second_* position, two charges
// result_o   out   valid/ready   energy_term, grad_x/y/z, zero_distance, saturated
//
// one pair enters per cycle while the output word is not waiting
// the pipeline is the 5 prep stages, the 32-step square root, the 31-step direction
// cosine divide, one multiply stage, the 64-step quotient divide and 2 output stages
// reset clears the valid bits only
// while the output word waits, every stage holds and pair_i.ready is low
module coulomb_pair_energy_gradient_unit (
  input logic           clk_i,
  input logic           rst_ni,
  cpeg_pair_if.sink     pair_i,
  cpeg_result_if.source result_o
);

  localparam int unsigned AX = cpeg_pkg::AXES;

  logic                                     en;
  cpeg_pkg::pair_t                          pair;

  logic                                     prep_vld;
  cpeg_pkg::prep_t                          prep;
  logic [cpeg_pkg::RT_W-1:0]                rn;

  logic                                     sa_vld;
  cpeg_pkg::prep_t                          sa;
  logic [AX-1:0][cpeg_pkg::MAG_W-1:0]       dn;
  logic [AX-1:0][cpeg_pkg::CQ_QW-1:0]       cq;
  cpeg_pkg::norm_t                          nb;

  logic                                     sb_vld;
  cpeg_pkg::norm_t                          sb;

  logic                                     m_vld_q;
  cpeg_pkg::norm_t                          mb_q;
  logic [AX-1:0][cpeg_pkg::PROD_W-1:0]      prod_q;
  cpeg_pkg::tail_t                          tail_d;

  logic                                     td_vld;
  cpeg_pkg::tail_t                          td;
  logic [cpeg_pkg::QUO_W-1:0]               equo;
  logic [AX-1:0][cpeg_pkg::QUO_W-1:0]       gquo;

  logic                                     f1_vld_q;
  cpeg_pkg::tail_t                          f1_q;
  logic [cpeg_pkg::QUO_W-1:0]               emag_q;
  logic [AX-1:0][cpeg_pkg::QUO_W-1:0]       gmag_q;

  cpeg_pkg::clip_t                          ce;
  cpeg_pkg::clip_t [AX-1:0]                 cg;
  logic                                     kill;

  logic                                     out_vld_q;
  logic [cpeg_pkg::OUT_W-1:0]               energy_q;
  logic [AX-1:0][cpeg_pkg::OUT_W-1:0]       grad_q;
  logic                                     zero_q;
  logic                                     sat_q;

  assign en           = !out_vld_q || result_o.ready;
  assign pair_i.ready = en;

  always_comb begin
    pair.operation     = cpeg_pkg::op_e'(pair_i.operation);
    pair.excluded      = pair_i.excluded;
    pair.first_x       = pair_i.first_x;
    pair.first_y       = pair_i.first_y;
    pair.first_z       = pair_i.first_z;
    pair.second_x      = pair_i.second_x;
    pair.second_y      = pair_i.second_y;
    pair.second_z      = pair_i.second_z;
    pair.first_charge  = pair_i.first_charge;
    pair.second_charge = pair_i.second_charge;
  end

  cpeg_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pair_i.valid),
    .pair_i  (pair),
    .valid_o (prep_vld),
    .prep_o  (prep)
  );

  cpeg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (prep.r2n),
    .root_o (rn)
  );

  cpeg_delay #(
    .W ($bits(cpeg_pkg::prep_t)),
    .D (cpeg_pkg::SQRT_LAT)
  ) u_dly_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (prep_vld),
    .dat_i  (prep),
    .vld_o  (sa_vld),
    .dat_o  (sa)
  );

  // scaled axis lengths, at most rn
  always_comb begin
    for (int i = 0; i < AX; i++) begin
      dn[i] = cpeg_pkg::MAG_W'(cpeg_pkg::R2_W'(sa.magp[i]) << sa.k);
    end
    nb.op   = sa.op;
    nb.excl = sa.excl;
    nb.zero = sa.zero;
    nb.qneg = sa.qneg;
    nb.s    = sa.s;
    nb.dneg = sa.dneg;
    nb.aq   = sa.aq;
    nb.k    = sa.k;
    nb.r2n  = sa.r2n;
    nb.rn   = rn;
  end

  for (genvar a = 0; a < AX; a++) begin : g_cos
    cpeg_div #(
      .DW (cpeg_pkg::RT_W),
      .QW (cpeg_pkg::CQ_QW)
    ) u_div_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .hi_i  ({1'b0, dn[a][cpeg_pkg::MAG_W-1:1]}),
      .lo_i  ({dn[a][0], {cpeg_pkg::CQ_FRAC{1'b0}}}),
      .den_i (rn),
      .quo_o (cq[a])
    );
  end

  cpeg_delay #(
    .W ($bits(cpeg_pkg::norm_t)),
    .D (cpeg_pkg::CQ_QW)
  ) u_dly_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sa_vld),
    .dat_i  (nb),
    .vld_o  (sb_vld),
    .dat_o  (sb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q   <= sb_vld;
      f1_vld_q  <= td_vld;
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mb_q <= sb;
      for (int i = 0; i < AX; i++) begin
        prod_q[i] <= sb.aq * cq[i];
      end
    end
  end

  // shifts that turn the fixed 2^64 quotients into the wanted scale
  always_comb begin
    tail_d.excl = mb_q.excl;
    tail_d.zero = mb_q.zero;
    tail_d.qneg = mb_q.qneg;
    tail_d.dneg = mb_q.dneg;
    tail_d.gsh  = cpeg_pkg::GSH_W'(cpeg_pkg::GSH_BASE - 2 * int'(mb_q.k) + 2 * int'(mb_q.s));
    tail_d.esh  = cpeg_pkg::ESH_W'(cpeg_pkg::ESH_BASE - int'(mb_q.k) + int'(mb_q.s)
                  + int'(mb_q.op == cpeg_pkg::OP_CROSS));
  end

  cpeg_div #(
    .DW (cpeg_pkg::RT_W),
    .QW (cpeg_pkg::QUO_W)
  ) u_div_energy (
    .clk_i (clk_i),
    .en_i  (en),
    .hi_i  (cpeg_pkg::RT_W'(mb_q.aq)),
    .lo_i  ('0),
    .den_i (mb_q.rn),
    .quo_o (equo)
  );

  for (genvar a = 0; a < AX; a++) begin : g_grad
    cpeg_div #(
      .DW (cpeg_pkg::R2_W),
      .QW (cpeg_pkg::QUO_W)
    ) u_div_grad (
      .clk_i (clk_i),
      .en_i  (en),
      .hi_i  (cpeg_pkg::R2_W'(prod_q[a])),
      .lo_i  ('0),
      .den_i (mb_q.r2n),
      .quo_o (gquo[a])
    );
  end

  cpeg_delay #(
    .W ($bits(cpeg_pkg::tail_t)),
    .D (cpeg_pkg::QUO_W)
  ) u_dly_quo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m_vld_q),
    .dat_i  (tail_d),
    .vld_o  (td_vld),
    .dat_o  (td)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q   <= td;
      emag_q <= equo >> td.esh;
      for (int i = 0; i < AX; i++) begin
        gmag_q[i] <= gquo[i] >> td.gsh;
      end
    end
  end

  // clip, sign and force zeros
  always_comb begin
    kill = f1_q.excl || f1_q.zero;
    ce   = cpeg_pkg::clip_sign(emag_q, f1_q.qneg);
    for (int i = 0; i < AX; i++) begin
      cg[i] = cpeg_pkg::clip_sign(gmag_q[i], !(f1_q.qneg ^ f1_q.dneg[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      energy_q <= kill ? '0 : ce.val;
      for (int i = 0; i < AX; i++) begin
        grad_q[i] <= kill ? '0 : cg[i].val;
      end
      zero_q <= f1_q.zero && !f1_q.excl;
      sat_q  <= !kill && (ce.sat || cg[0].sat || cg[1].sat || cg[2].sat);
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.energy_term   = energy_q;
  assign result_o.grad_x        = grad_q[0];
  assign result_o.grad_y        = grad_q[1];
  assign result_o.grad_z        = grad_q[2];
  assign result_o.zero_distance = zero_q;
  assign result_o.saturated     = sat_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(f1_vld_q) && $stable(m_vld_q))
    else $error("pipeline moved during stall");

  a_zero_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.zero_distance && result_o.saturated))
    else $error("zero distance and saturation together");

  a_zero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.zero_distance |->
      result_o.energy_term == '0 && result_o.grad_x == '0 &&
      result_o.grad_y == '0 && result_o.grad_z == '0)
    else $error("coincident pair with nonzero word");

  a_sat_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.saturated |->
      result_o.grad_x == cpeg_pkg::POS_CAP || result_o.grad_x == cpeg_pkg::NEG_CAP ||
      result_o.grad_y == cpeg_pkg::POS_CAP || result_o.grad_y == cpeg_pkg::NEG_CAP ||
      result_o.grad_z == cpeg_pkg::POS_CAP || result_o.grad_z == cpeg_pkg::NEG_CAP ||
      result_o.energy_term == cpeg_pkg::POS_CAP ||
      result_o.energy_term == cpeg_pkg::NEG_CAP)
    else $error("saturation flagged without a clipped field");

endmodule
